FILE: hdl/tes_pkg.sv
// Package with the shared types and constants of the thermal escalation supervisor.
package tes_pkg;

    localparam int TEMP_W  = 10;
    localparam int KIND_W  = 2;
    localparam int MODE_W  = 2;
    localparam int DIGIT_W = 6;
    localparam int TICK_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Operating modes.
    localparam logic [MODE_W-1:0] MODE_NORMAL    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EMERGENCY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ABNORMAL  = 2'd2;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EMERGENCY_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_FLOOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_LIMIT      = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [TEMP_W-1:0] EMERGENCY_LIMIT_RST = 10'd50;
    localparam logic [TEMP_W-1:0] BUTTON_FLOOR_RST    = 10'd40;
    localparam logic [TICK_W-1:0] TICK_LIMIT_RST      = 4'd14;

    localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;

    // One result item.
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               report_valid;
        logic [DIGIT_W-1:0] digit_hundreds;
        logic [DIGIT_W-1:0] digit_tens;
        logic [DIGIT_W-1:0] digit_ones;
        logic               fan_update;
        logic [TEMP_W-1:0]  fan_temperature;
        logic               shutdown;
    } tes_result_t;

endpackage

FILE: hdl/tes_in_if.sv
// Input channel of the thermal escalation supervisor: valid, ready and the input item.
interface tes_in_if import tes_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TEMP_W-1:0] temperature;

    modport source (output valid, kind, temperature, input ready);
    modport sink   (input valid, kind, temperature, output ready);
endinterface

FILE: hdl/tes_out_if.sv
// Output channel of the thermal escalation supervisor: valid, ready and the result item.
interface tes_out_if import tes_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic               report_valid;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_ones;
    logic               fan_update;
    logic [TEMP_W-1:0]  fan_temperature;
    logic               shutdown;

    modport source (output valid, mode, report_valid, digit_hundreds, digit_tens, digit_ones,
                    fan_update, fan_temperature, shutdown, input ready);
    modport sink   (input valid, mode, report_valid, digit_hundreds, digit_tens, digit_ones,
                    fan_update, fan_temperature, shutdown, output ready);
endinterface

FILE: hdl/thermal_escalation_supervisor.sv
// Top level of the thermal escalation supervisor: mode control, digit report and shutdown.
//
// The supervisor watches temperature samples, emergency timer ticks and button presses and
// produces exactly one result item for every input item, in order. An item is captured in an
// input register, evaluated against the mode state by one short combinational pass, and the
// result lands in an output register; the block accepts one item every cycle as long as the
// output side takes results. The throughput rests on the state update: mode, stored
// temperature, tick count and timer flag are read and written in the same cycle that the item
// is evaluated, so consecutive items always see the state left by the previous one. When the
// output is stalled the input register holds its item and input ready drops only once both
// registers are full. The three ASCII digits come from constant reciprocal multiplications,
// not a divider. Configuration registers are written through a plain write port and should
// only change while the block is idle. Abnormal mode latches until reset.
module thermal_escalation_supervisor import tes_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    tes_in_if.sink                in_ch,
    tes_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [TEMP_W-1:0] emergency_limit_reg;
    logic [TEMP_W-1:0] button_floor_reg;
    logic [TICK_W-1:0] tick_limit_reg;

    // Input register.
    logic              s1_valid_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic [TEMP_W-1:0] s1_temp_reg;

    // Supervisor state.
    logic [MODE_W-1:0] mode_reg,      mode_next;
    logic [TEMP_W-1:0] last_temp_reg, last_temp_next;
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic              timer_run_reg, timer_run_next;

    // Output register.
    logic              out_valid_reg;
    tes_result_t       result_reg, result_next;

    logic out_free;
    logic s1_fire;
    logic in_fire;

    // Digit conversion signals.
    logic [15:0]       hund_prod;
    logic [3:0]        hund_q;
    logic [10:0]       hund_sub;
    logic [10:0]       rem_wide;
    logic [6:0]        rem;
    logic [14:0]       tens_prod;
    logic [3:0]        tens_q;
    logic [6:0]        tens_sub;
    logic [6:0]        ones_wide;
    logic [TICK_W:0]   tick_inc;

    assign out_free     = !out_valid_reg || out_ch.ready;
    assign s1_fire      = s1_valid_reg && out_free;
    assign in_ch.ready  = !s1_valid_reg || out_free;
    assign in_fire      = in_ch.valid && in_ch.ready;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emergency_limit_reg <= EMERGENCY_LIMIT_RST;
            button_floor_reg    <= BUTTON_FLOOR_RST;
            tick_limit_reg      <= TICK_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EMERGENCY_LIMIT: emergency_limit_reg <= cfg_wdata[TEMP_W-1:0];
                CFG_BUTTON_FLOOR:    button_floor_reg    <= cfg_wdata[TEMP_W-1:0];
                CFG_TICK_LIMIT:      tick_limit_reg      <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: loads whenever the channel hands over an item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg <= in_ch.kind;
            s1_temp_reg <= in_ch.temperature;
        end
    end

    // Temperature to decimal digits. The reciprocal 41/4096 gives the exact quotient by 100
    // for every 10-bit value, and 205/2048 the exact quotient by 10 for values below 100.
    always_comb
    begin
        hund_prod = {6'd0, s1_temp_reg} * 16'd41;
        hund_q    = hund_prod[15:12];
        hund_sub  = {7'd0, hund_q} * 11'd100;
        rem_wide  = {1'b0, s1_temp_reg} - hund_sub;
        rem       = rem_wide[6:0];
        tens_prod = {8'd0, rem} * 15'd205;
        tens_q    = tens_prod[14:11];
        tens_sub  = {3'd0, tens_q} * 7'd10;
        ones_wide = rem - tens_sub;
    end

    // One evaluation pass: next state and the result item.
    always_comb
    begin
        mode_next       = mode_reg;
        last_temp_next  = last_temp_reg;
        tick_count_next = tick_count_reg;
        timer_run_next  = timer_run_reg;
        result_next     = '0;
        tick_inc        = {1'b0, tick_count_reg} + 5'd1;

        case (s1_kind_reg)
            KIND_SAMPLE:
            begin
                if (mode_reg == MODE_NORMAL)
                begin
                    timer_run_next  = 1'b0;
                    last_temp_next  = s1_temp_reg;
                    if (s1_temp_reg > emergency_limit_reg)
                    begin
                        mode_next = MODE_EMERGENCY;
                    end
                    result_next.report_valid    = 1'b1;
                    result_next.fan_update      = 1'b1;
                    result_next.fan_temperature = s1_temp_reg;
                end
                else if (mode_reg == MODE_EMERGENCY && !timer_run_reg)
                begin
                    // The first sample in emergency starts the timer and refreshes the fan
                    // from the stored reading, not from the new one.
                    timer_run_next              = 1'b1;
                    result_next.fan_update      = 1'b1;
                    result_next.fan_temperature = last_temp_reg;
                end
            end
            KIND_TICK:
            begin
                if (timer_run_reg)
                begin
                    if (tick_inc >= {1'b0, tick_limit_reg})
                    begin
                        mode_next            = MODE_ABNORMAL;
                        tick_count_next      = '0;
                        timer_run_next       = 1'b0;
                        result_next.shutdown = 1'b1;
                    end
                    else
                    begin
                        tick_count_next          = tick_inc[TICK_W-1:0];
                        last_temp_next           = s1_temp_reg;
                        result_next.report_valid = 1'b1;
                        if (s1_temp_reg <= emergency_limit_reg)
                        begin
                            mode_next       = MODE_NORMAL;
                            tick_count_next = '0;
                            timer_run_next  = 1'b0;
                        end
                    end
                end
            end
            KIND_BUTTON:
            begin
                // The button acts in every mode, abnormal included.
                if (last_temp_reg > button_floor_reg && last_temp_reg <= emergency_limit_reg)
                begin
                    result_next.shutdown = 1'b1;
                end
            end
            default: ;
        endcase

        if (result_next.report_valid)
        begin
            result_next.digit_hundreds = ASCII_ZERO + {2'd0, hund_q};
            result_next.digit_tens     = ASCII_ZERO + {2'd0, tens_q};
            result_next.digit_ones     = ASCII_ZERO + {2'd0, ones_wide[3:0]};
        end
        result_next.mode = mode_next;
    end

    // State update, one item per cycle unless the output is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NORMAL;
            last_temp_reg  <= '0;
            tick_count_reg <= '0;
            timer_run_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            mode_reg       <= mode_next;
            last_temp_reg  <= last_temp_next;
            tick_count_reg <= tick_count_next;
            timer_run_reg  <= timer_run_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.mode            = result_reg.mode;
    assign out_ch.report_valid    = result_reg.report_valid;
    assign out_ch.digit_hundreds  = result_reg.digit_hundreds;
    assign out_ch.digit_tens      = result_reg.digit_tens;
    assign out_ch.digit_ones      = result_reg.digit_ones;
    assign out_ch.fan_update      = result_reg.fan_update;
    assign out_ch.fan_temperature = result_reg.fan_temperature;
    assign out_ch.shutdown        = result_reg.shutdown;

    // Abnormal mode is left only through reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_ABNORMAL |=> mode_reg == MODE_ABNORMAL)
        else $error("abnormal mode was left without reset");

    // The emergency timer only runs in emergency mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        timer_run_reg |-> mode_reg == MODE_EMERGENCY)
        else $error("emergency timer running outside emergency mode");

    // The tick count always stays below the largest tick limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_count_reg != 4'd15)
        else $error("tick count reached an unreachable value");

    // A reported hundreds digit stays within the ASCII range the conversion can produce.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.report_valid |->
            result_reg.digit_hundreds >= ASCII_ZERO && result_reg.digit_hundreds <= 6'd58)
        else $error("hundreds digit out of range");

endmodule
